// ===== hw/rtl/msg_pkg.sv =====
// ----------------------------------------------------------------------------
// msg_pkg
// shared types and constants for the masking share generator: beat
// structs, command codes, register indexes and the xorshift step
// ----------------------------------------------------------------------------
package msg_pkg;

   localparam int          DEF_MAX_ORDER = 15;
   localparam int          DEF_MAX_FILL  = 32;
   localparam int          RESULT_CAP    = 32;
   localparam logic [31:0] SEED_RESET    = 32'd67676767;
   localparam logic [3:0]  ORDER_RESET   = 4'd1;

   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 17;
   localparam int SHIFT_C = 5;

   typedef enum logic [2:0] {
      CMD_MASK_BOOL    = 3'd0,
      CMD_MASK_ISW     = 3'd1,
      CMD_MASK_ARITH   = 3'd2,
      CMD_FILL         = 3'd3,
      CMD_UNMASK_BOOL  = 3'd4,
      CMD_UNMASK_ARITH = 3'd5,
      CMD_RESET_CNT    = 3'd6
   } cmd_type;

   typedef enum logic {
      CSR_SEED  = 1'b0,
      CSR_ORDER = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] value;
      logic [5:0]  fill_count;
      logic        share_last;
   } req_type;

   typedef struct packed {
      logic [31:0] share;
      logic [4:0]  share_index;
      logic        run_last;
      logic [31:0] draw_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic advance;
   } prng_ctrl_type;

   typedef struct packed {
      logic [31:0] next_word;
      logic [31:0] count;
      logic [31:0] next_count;
   } prng_stat_type;

   function automatic logic [31:0] xorshift(input logic [31:0] x);
      logic [31:0] a;
      logic [31:0] b;
      a = x ^ (x << SHIFT_A);
      b = a ^ (a >> SHIFT_B);
      return b ^ (b << SHIFT_C);
   endfunction

endpackage

// ===== hw/rtl/msg_prng.sv =====
// ----------------------------------------------------------------------------
// msg_prng
// xorshift32 generator with its draw counter; seed load, counter clear
// and one step per advance
// ----------------------------------------------------------------------------
module msg_prng (
   input  logic                  clock,
   input  logic                  reset,
   input  msg_pkg::prng_ctrl_type ctrl,
   input  logic [31:0]           seed,
   output msg_pkg::prng_stat_type stat
);
   import msg_pkg::*;

   logic [31:0] word_ff;
   logic [31:0] word_in;
   logic [31:0] count_ff;
   logic [31:0] count_in;

   always_comb begin
      stat.next_word  = xorshift(word_ff);
      stat.count      = count_ff;
      stat.next_count = count_ff + 32'd1;
      word_in  = word_ff;
      count_in = count_ff;
      if (ctrl.load) begin
         word_in  = seed;
         count_in = '0;
      end else if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.advance) begin
         word_in  = stat.next_word;
         count_in = stat.next_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= SEED_RESET;
         count_ff <= '0;
      end else begin
         word_ff  <= word_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/msg_seq.sv =====
// ----------------------------------------------------------------------------
// msg_seq
// run sequencer: takes one command, then emits one share a cycle while
// its output register is free, folding each draw into the closing share
// ----------------------------------------------------------------------------
module msg_seq #(
   parameter int MAX_ORDER = msg_pkg::DEF_MAX_ORDER,
   parameter int MAX_FILL  = msg_pkg::DEF_MAX_FILL
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [3:0]             masking_order,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  msg_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output msg_pkg::rsp_type       rsp_data,
   output msg_pkg::prng_ctrl_type prng_ctrl,
   input  msg_pkg::prng_stat_type prng_stat
);
   import msg_pkg::*;

   localparam int FILL_CAP = (MAX_FILL < RESULT_CAP) ? MAX_FILL : RESULT_CAP;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_GEN  = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  left_ff, left_in;
   logic        close_ff, close_in;
   logic        arith_ff, arith_in;
   logic [31:0] acc_ff, acc_in;
   logic [4:0]  idx_ff, idx_in;
   logic [31:0] sum_ff, sum_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        slot_free;
   logic [3:0]  order_sat;
   logic [5:0]  fill_sat;
   logic [31:0] sum_new;
   logic        draw_last;

   always_comb begin
      slot_free = !rsp_valid_ff || !rsp_stall;
      order_sat = ({1'b0, masking_order} > 5'(MAX_ORDER)) ? 4'(MAX_ORDER) : masking_order;
      fill_sat  = (req_data.fill_count > 6'(FILL_CAP)) ? 6'(FILL_CAP) : req_data.fill_count;
      sum_new   = (cmd_type'(req_data.command) == CMD_UNMASK_BOOL) ?
                  (sum_ff ^ req_data.value) : (sum_ff + req_data.value);
      draw_last = !close_ff && (left_ff == 6'd1);

      state_in     = state_ff;
      left_in      = left_ff;
      close_in     = close_ff;
      arith_in     = arith_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      prng_ctrl    = '0;
      req_stall    = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in   = '0;
               acc_in   = req_data.value;
               close_in = 1'b1;
               arith_in = 1'b0;
               case (cmd_type'(req_data.command))
                  CMD_MASK_BOOL: begin
                     left_in  = {2'b00, order_sat};
                     state_in = ST_GEN;
                  end
                  CMD_MASK_ISW: begin
                     left_in  = {1'b0, order_sat, 1'b0};
                     state_in = ST_GEN;
                  end
                  CMD_MASK_ARITH: begin
                     left_in  = {2'b00, order_sat};
                     arith_in = 1'b1;
                     state_in = ST_GEN;
                  end
                  CMD_FILL: begin
                     left_in  = fill_sat;
                     close_in = 1'b0;
                     if (fill_sat != '0) begin
                        state_in = ST_GEN;
                     end
                  end
                  CMD_UNMASK_BOOL, CMD_UNMASK_ARITH: begin
                     if (req_data.share_last) begin
                        acc_in   = sum_new;
                        sum_in   = '0;
                        left_in  = '0;
                        state_in = ST_GEN;
                     end else begin
                        sum_in = sum_new;
                     end
                  end
                  CMD_RESET_CNT: begin
                     prng_ctrl.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_GEN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (left_ff != '0) begin
                  prng_ctrl.advance = 1'b1;
                  rsp_data_in = '{share:       prng_stat.next_word,
                                  share_index: idx_ff,
                                  run_last:    draw_last,
                                  draw_count:  prng_stat.next_count};
                  acc_in  = arith_ff ? (acc_ff - prng_stat.next_word)
                                     : (acc_ff ^ prng_stat.next_word);
                  left_in = left_ff - 6'd1;
                  idx_in  = idx_ff + 5'd1;
                  if (draw_last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_data_in = '{share:       acc_ff,
                                  share_index: idx_ff,
                                  run_last:    1'b1,
                                  draw_count:  prng_stat.count};
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         left_ff      <= '0;
         close_ff     <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         close_ff     <= close_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      arith_ff    <= arith_in;
      acc_ff      <= acc_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_gen_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN) |-> (left_ff != '0 || close_ff))
      else $error("run active with nothing left to emit");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN && slot_free && (left_ff == '0 || draw_last))
      |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_data_ff.run_last))
      else $error("final beat did not end the run");

   a_mask_starts_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid &&
       (req_data.command == CMD_MASK_BOOL || req_data.command == CMD_MASK_ISW ||
        req_data.command == CMD_MASK_ARITH))
      |=> (state_ff == ST_GEN))
      else $error("masking command did not start a run");

   a_unmask_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_data.share_last &&
       (req_data.command == CMD_UNMASK_BOOL || req_data.command == CMD_UNMASK_ARITH))
      |=> (sum_ff == '0 && state_ff == ST_GEN))
      else $error("unmask accumulator not cleared on last share");
`endif

endmodule

// ===== hw/rtl/masking_share_generator.sv =====
// ----------------------------------------------------------------------------
// masking_share_generator
// boolean, isw and arithmetic masking, random fill and streamed unmasking
// around one xorshift32 generator
//
// req channel: one beat carries a command, a secret or share value, a fill
// count and a last flag. rsp channel: one beat per share, with its index in
// the run, a last flag and the draw counter after that share.
// csr port: index 0 writes the seed (reloads the generator and clears the
// draw counter), index 1 writes the masking order d.
// a masking run gives d random shares (2d for isw) plus one closing share,
// a fill run gives up to 32 random words, an unmask beat marked last gives
// one result; other commands give no beat.
// a request beat moves the sequencer into its generate state, which then
// registers the shares into the output register, one per cycle from the
// generator step while the output register is free; req_stall is high
// until the run's last share is registered.
// rsp_stall holds the output register and pauses the run; nothing is lost.
// reset: generator at 67676767, counter and unmask sum at zero, order 1.
// ----------------------------------------------------------------------------
module masking_share_generator #(
   parameter int MAX_ORDER = msg_pkg::DEF_MAX_ORDER,
   parameter int MAX_FILL  = msg_pkg::DEF_MAX_FILL
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  msg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output msg_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);
   import msg_pkg::*;

   logic [3:0]    order_ff;
   logic [3:0]    order_in;
   prng_ctrl_type seq_ctrl;
   prng_ctrl_type prng_ctrl;
   prng_stat_type prng_stat;

   always_comb begin
      order_in = order_ff;
      if (csr_write_en && csr_idx_type'(csr_index) == CSR_ORDER) begin
         order_in = csr_wdata[3:0];
      end
      prng_ctrl      = seq_ctrl;
      prng_ctrl.load = csr_write_en && csr_idx_type'(csr_index) == CSR_SEED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
      end else begin
         order_ff <= order_in;
      end
   end

   msg_prng u_prng (
      .clock (clock),
      .reset (reset),
      .ctrl  (prng_ctrl),
      .seed  (csr_wdata),
      .stat  (prng_stat)
   );

   msg_seq #(
      .MAX_ORDER (MAX_ORDER),
      .MAX_FILL  (MAX_FILL)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .masking_order (order_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .prng_ctrl     (seq_ctrl),
      .prng_stat     (prng_stat)
   );

endmodule

// ===== bench/tb_share_pkg.sv =====
// ----------------------------------------------------------------------------
// tb_share_pkg
// scoreboard for the masking share generator bench: keeps its own xorshift
// generator, draw counter, unmask accumulator and order, turns every accepted
// request beat into the share beats it must cause and checks response beats
// against them in order, field by field
// ----------------------------------------------------------------------------
package tb_share_pkg;
   import msg_pkg::*;

   class share_scoreboard;
      logic [31:0] prng_word;
      logic [31:0] draws;
      logic [31:0] unmask_acc;
      logic [3:0]  order;
      rsp_type     expected_q[$];
      int          errors;
      int          beats_seen;

      function new();
         prng_word  = SEED_RESET;
         draws      = '0;
         unmask_acc = '0;
         order      = ORDER_RESET;
         errors     = 0;
         beats_seen = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("%s", msg);
         end
      endfunction

      function void write_csr(csr_idx_type idx, logic [31:0] wdata);
         if (idx == CSR_SEED) begin
            prng_word = wdata;
            draws     = '0;
         end else begin
            order = wdata[3:0];
         end
      endfunction

      function logic [31:0] next_random();
         logic [31:0] x;
         x = prng_word;
         x = x ^ (x << SHIFT_A);
         x = x ^ (x >> SHIFT_B);
         x = x ^ (x << SHIFT_C);
         prng_word = x;
         draws     = draws + 32'd1;
         return x;
      endfunction

      function void push_share(logic [31:0] sh, int k, logic last);
         rsp_type e;
         e.share       = sh;
         e.share_index = k[4:0];
         e.run_last    = last;
         e.draw_count  = draws;
         expected_q.push_back(e);
      endfunction

      function void masked_run(logic [31:0] secret, int randoms, bit arith);
         logic [31:0] acc;
         logic [31:0] r;
         acc = secret;
         for (int i = 0; i < randoms; i++) begin
            r = next_random();
            if (arith) begin
               acc = acc - r;
            end else begin
               acc = acc ^ r;
            end
            push_share(r, i, 1'b0);
         end
         push_share(acc, randoms, 1'b1);
      endfunction

      function void note_request(req_type q);
         int d;
         int n;
         d = order;
         if (d > DEF_MAX_ORDER) d = DEF_MAX_ORDER;
         if (2 * d + 1 > RESULT_CAP) d = (RESULT_CAP - 1) / 2;
         case (q.command)
            CMD_MASK_BOOL: begin
               masked_run(q.value, d, 1'b0);
            end
            CMD_MASK_ISW: begin
               masked_run(q.value, 2 * d, 1'b0);
            end
            CMD_MASK_ARITH: begin
               masked_run(q.value, d, 1'b1);
            end
            CMD_FILL: begin
               n = q.fill_count;
               if (n > DEF_MAX_FILL) n = DEF_MAX_FILL;
               if (n > RESULT_CAP) n = RESULT_CAP;
               for (int i = 0; i < n; i++) begin
                  push_share(next_random(), i, (i == n - 1));
               end
            end
            CMD_UNMASK_BOOL, CMD_UNMASK_ARITH: begin
               if (q.command == CMD_UNMASK_BOOL) begin
                  unmask_acc = unmask_acc ^ q.value;
               end else begin
                  unmask_acc = unmask_acc + q.value;
               end
               if (q.share_last) begin
                  push_share(unmask_acc, 0, 1'b1);
                  unmask_acc = '0;
               end
            end
            CMD_RESET_CNT: begin
               draws = '0;
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            flag($sformatf("beat %0d %s: expected %h, got %h", beats_seen, name, want, got));
         end
      endfunction

      function void check_share(rsp_type got);
         rsp_type want;
         beats_seen++;
         if (expected_q.size() == 0) begin
            flag($sformatf("beat %0d unexpected: share %h index %0d last %b count %h",
                           beats_seen, got.share, got.share_index, got.run_last,
                           got.draw_count));
            return;
         end
         want = expected_q.pop_front();
         compare_field("share", want.share, got.share);
         compare_field("share_index", 32'(want.share_index), 32'(got.share_index));
         compare_field("run_last", 32'(want.run_last), 32'(got.run_last));
         compare_field("draw_count", want.draw_count, got.draw_count);
      endfunction
   endclass

endpackage

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// bench for the masking share generator: directed beats for field extremes,
// every command and the corner cases, then random traffic under several seed
// and order settings, with bursty requests and a stalling receiver; every
// response beat is checked against the scoreboard's own prediction
// ----------------------------------------------------------------------------
module tb_top;
   import msg_pkg::*;
   import tb_share_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_UNKNOWN   = 3'd7;
   localparam int         SETTLE_CYCLES = 40;
   localparam int         CYCLE_LIMIT   = 500000;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   req_type     req_data     = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic        csr_index    = 1'b0;
   logic [31:0] csr_wdata    = '0;

   share_scoreboard sb = new();
   int              burst_left  = 0;
   int              stall_hold  = 0;
   int              cycle_count = 0;

   masking_share_generator uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_request(req_data);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_share(rsp_data);
      end
   end

   // receiver: free stretches, random stalls and stall bursts
   always @(posedge clock) begin
      int mode;
      mode = $urandom_range(0, 9);
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else if (mode < 4) begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(5, 30);
      end else if (mode < 7) begin
         rsp_stall  <= 1'($urandom_range(0, 1));
      end else begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(1, 8);
      end
   end

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom();
   endfunction

   task automatic send_item(input logic [2:0] cmd, input logic [31:0] value,
                            input logic [5:0] fill, input logic last);
      req_data.command    <= cmd;
      req_data.value      <= value;
      req_data.fill_count <= fill;
      req_data.share_last <= last;
      req_valid           <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left == 0) begin
         req_valid  <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] seed, input logic [31:0] order_word);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SEED;
      csr_wdata    <= seed;
      @(posedge clock);
      sb.write_csr(CSR_SEED, seed);
      csr_index    <= CSR_ORDER;
      csr_wdata    <= order_word;
      @(posedge clock);
      sb.write_csr(CSR_ORDER, order_word);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_directed();
      send_item(CMD_MASK_BOOL, 32'h0000_0000, 6'd0, 1'b0);
      send_item(CMD_MASK_BOOL, 32'hFFFF_FFFF, 6'd63, 1'b1);
      send_item(CMD_MASK_ISW, 32'h0000_0000, 6'd1, 1'b0);
      send_item(CMD_MASK_ISW, 32'hFFFF_FFFF, 6'd32, 1'b1);
      send_item(CMD_MASK_ARITH, 32'h0000_0000, 6'd0, 1'b1);
      send_item(CMD_MASK_ARITH, 32'hFFFF_FFFF, 6'd63, 1'b0);
      send_item(CMD_FILL, 32'hFFFF_FFFF, 6'd0, 1'b0);
      send_item(CMD_FILL, 32'h0000_0000, 6'd1, 1'b1);
      send_item(CMD_FILL, $urandom(), 6'd32, 1'b0);
      send_item(CMD_FILL, $urandom(), 6'd63, 1'b1);
      // mixed xor and add shares in one stream
      send_item(CMD_UNMASK_BOOL, $urandom(), 6'd5, 1'b0);
      send_item(CMD_UNMASK_ARITH, $urandom(), 6'd0, 1'b0);
      send_item(CMD_UNMASK_BOOL, $urandom(), 6'd63, 1'b1);
      send_item(CMD_UNMASK_ARITH, 32'hFFFF_FFFF, 6'd2, 1'b0);
      send_item(CMD_UNMASK_ARITH, 32'h0000_0001, 6'd2, 1'b1);
      send_item(CMD_UNMASK_BOOL, 32'h0000_0000, 6'd0, 1'b1);
      send_item(CMD_RESET_CNT, $urandom(), 6'd17, 1'b1);
      send_item(CMD_UNKNOWN, $urandom(), 6'd4, 1'b1);
      send_item(CMD_MASK_BOOL, $urandom(), 6'd9, 1'b0);
      send_item(CMD_UNMASK_ARITH, $urandom(), 6'd9, 1'b1);
   endtask

   task automatic run_random(input int items);
      int done;
      int pick;
      int len;
      done = 0;
      while (done < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            send_item(CMD_MASK_BOOL, pick_value(), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)));
            done++;
         end else if (pick < 28) begin
            send_item(CMD_MASK_ISW, pick_value(), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)));
            done++;
         end else if (pick < 42) begin
            send_item(CMD_MASK_ARITH, pick_value(), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)));
            done++;
         end else if (pick < 56) begin
            send_item(CMD_FILL, $urandom(), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)));
            done++;
         end else if (pick < 82) begin
            len = $urandom_range(1, 5);
            for (int k = 0; k < len; k++) begin
               send_item($urandom_range(0, 1) ? CMD_UNMASK_ARITH : CMD_UNMASK_BOOL,
                         pick_value(), 6'($urandom_range(0, 63)), (k == len - 1));
            end
            done += len;
         end else if (pick < 89) begin
            send_item(CMD_RESET_CNT, $urandom(), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)));
            done++;
         end else if (pick < 95) begin
            // stream left open, later shares fold into it
            send_item($urandom_range(0, 1) ? CMD_UNMASK_ARITH : CMD_UNMASK_BOOL,
                      pick_value(), 6'($urandom_range(0, 63)), 1'b0);
            done++;
         end else begin
            send_item(CMD_UNKNOWN, $urandom(), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      settle();
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_random(30);
      settle();
      configure(32'h0000_0000, 32'h0000_0000);
      run_random(30);
      settle();
      configure($urandom(), ($urandom() & ~32'hF) | 32'($urandom_range(0, 15)));
      run_random(30);
      settle();
      configure($urandom(), ($urandom() & ~32'hF) | 32'd1);
      run_random(30);
      settle();
      configure($urandom(), ($urandom() & ~32'hF) | 32'($urandom_range(0, 15)));
      run_random(30);
      settle();
      configure($urandom(), 32'd15);
      run_random(30);
      settle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
